@@ sv/sss_pkg.sv @@
// shared types and constants for the self-synchronizing scrambler
// no dependencies; used by sss_cell, sss_taps and self_sync_scrambler_top
`default_nettype none

package sss_pkg;

  localparam int unsigned MAX_ORDER = 64;
  localparam int unsigned REG_W     = MAX_ORDER;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_CELLS = REG_W / BYTE_W;
  localparam int unsigned ORDER_W   = 7;
  localparam int unsigned TAP_W     = $clog2(REG_W);
  localparam int unsigned STEP_W    = $clog2(BYTE_W);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  localparam logic [ORDER_W-1:0] MIN_ORDER   = ORDER_W'(2);
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(7);
  localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(MAX_ORDER);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_ORDER = 2'd1,
    CFG_FILL  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_SCRAMBLE   = 1'b0,
    MODE_DESCRAMBLE = 1'b1
  } mode_e;

  typedef struct packed {
    logic              en;
    logic              restart;
    logic [BYTE_W-1:0] fill;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/self_sync_scrambler_top.sv @@
// Self-synchronizing scrambler/descrambler, one byte per item, msb first.
// Takes one item per clock and delivers its result in the next cycle from an
// output register; a new item is taken while a result waits unless the
// output is stalled. The 64-bit shift register lives in a row of eight byte
// cells that shift one byte per item. The cycle time is set by the eight
// dependent xor steps through the two 64-way tap selects.
// depends on sss_pkg, sss_cell, sss_taps
`default_nettype none

module self_sync_scrambler_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sss_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sss_pkg::BYTE_W-1:0]     in_data_i,
  input  wire logic                           in_restart_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [sss_pkg::BYTE_W-1:0]     out_data_o
);

  logic                          mode_q;
  logic [sss_pkg::ORDER_W-1:0]   order_q;
  logic [sss_pkg::BYTE_W-1:0]    fill_q;
  logic                          out_valid_q, out_valid_d;
  logic [sss_pkg::BYTE_W-1:0]    out_data_q, out_data_d;
  logic                          accept_in;
  sss_pkg::cell_ctrl_t           cell_ctrl;
  logic [sss_pkg::REG_W-1:0]     shift_q;
  logic [sss_pkg::REG_W-1:0]     eff;
  logic [sss_pkg::BYTE_W-1:0]    fed_byte;
  logic [sss_pkg::BYTE_W-1:0]    scr_byte;
  logic [sss_pkg::BYTE_W-1:0]    chain_in [sss_pkg::NUM_CELLS];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sss_pkg::MODE_SCRAMBLE;
      order_q <= sss_pkg::ORDER_RESET;
      fill_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sss_pkg::CFG_MODE:  mode_q  <= cfg_data_i[0];
        sss_pkg::CFG_ORDER: order_q <= cfg_data_i[sss_pkg::ORDER_W-1:0];
        sss_pkg::CFG_FILL:  fill_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign cell_ctrl.en      = accept_in;
  assign cell_ctrl.restart = in_restart_i;
  assign cell_ctrl.fill    = fill_q;

  // cell 0 takes the fed-back byte, every other cell its lower neighbor
  for (genvar i = 0; i < sss_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign chain_in[i] = fed_byte;
    end else begin : g_rest
      assign chain_in[i] = eff[i*sss_pkg::BYTE_W-1 -: sss_pkg::BYTE_W];
    end
    sss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .prev_i (chain_in[i]),
      .byte_o (shift_q[i*sss_pkg::BYTE_W +: sss_pkg::BYTE_W]),
      .eff_o  (eff[i*sss_pkg::BYTE_W +: sss_pkg::BYTE_W])
    );
  end

  sss_taps u_taps (
    .eff_i   (eff),
    .order_i (order_q),
    .mode_i  (mode_q),
    .data_i  (in_data_i),
    .data_o  (scr_byte),
    .fed_o   (fed_byte)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept_in) begin
      out_valid_d = 1'b1;
      out_data_d  = scr_byte;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> out_valid_o)
    else $error("accepted item produced no result");

  a_restart_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && in_restart_i |=>
      shift_q[sss_pkg::REG_W-1:sss_pkg::BYTE_W] ==
      {(sss_pkg::NUM_CELLS-1){$past(fill_q)}})
    else $error("restart did not load the fill pattern");

  a_chain_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && !in_restart_i |=>
      shift_q[sss_pkg::REG_W-1:sss_pkg::BYTE_W] ==
      $past(shift_q[sss_pkg::REG_W-sss_pkg::BYTE_W-1:0]))
    else $error("cell chain did not shift by one byte");

  a_descramble_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && mode_q == sss_pkg::MODE_DESCRAMBLE |=>
      shift_q[sss_pkg::BYTE_W-1:0] == $past(in_data_i))
    else $error("descrambler did not feed back the input byte");

  a_scramble_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && mode_q == sss_pkg::MODE_SCRAMBLE |=>
      shift_q[sss_pkg::BYTE_W-1:0] == out_data_o)
    else $error("scrambler did not feed back the output byte");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_in |=> shift_q == $past(shift_q))
    else $error("shift register moved without an item");

endmodule

`default_nettype wire

@@ sv/sss_cell.sv @@
// one byte of the scrambler shift register, handed to the next cell per item
// depends on sss_pkg
`default_nettype none

module sss_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sss_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [sss_pkg::BYTE_W-1:0]  prev_i,
  output logic      [sss_pkg::BYTE_W-1:0]  byte_o,
  output logic      [sss_pkg::BYTE_W-1:0]  eff_o
);

  logic [sss_pkg::BYTE_W-1:0] byte_q, byte_d;

  // restart replaces the held byte with the fill pattern before use
  assign eff_o  = ctrl_i.restart ? ctrl_i.fill : byte_q;
  assign byte_o = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.en) begin
      byte_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/sss_taps.sv @@
// tap selection and bit-serial xor over one byte, msb first
// depends on sss_pkg
`default_nettype none

module sss_taps (
  input  wire logic [sss_pkg::REG_W-1:0]   eff_i,
  input  wire logic [sss_pkg::ORDER_W-1:0] order_i,
  input  wire logic                        mode_i,
  input  wire logic [sss_pkg::BYTE_W-1:0]  data_i,
  output logic      [sss_pkg::BYTE_W-1:0]  data_o,
  output logic      [sss_pkg::BYTE_W-1:0]  fed_o
);

  logic [sss_pkg::ORDER_W-1:0] ord_sat;
  logic [sss_pkg::TAP_W-1:0]   end_tap;
  logic [sss_pkg::TAP_W-1:0]   mid_tap;

  always_comb begin
    ord_sat = order_i;
    if (order_i < sss_pkg::MIN_ORDER) begin
      ord_sat = sss_pkg::MIN_ORDER;
    end else if (order_i > sss_pkg::ORDER_MAX) begin
      ord_sat = sss_pkg::ORDER_MAX;
    end
  end

  assign end_tap = sss_pkg::TAP_W'(ord_sat - sss_pkg::ORDER_W'(1));
  assign mid_tap = sss_pkg::TAP_W'(ord_sat >> 1);

  // step j sees the register shifted by j; low bits come from earlier steps
  always_comb begin
    logic [sss_pkg::BYTE_W-1:0]  fed_s;
    logic [sss_pkg::ORDER_W-1:0] diff_e;
    logic [sss_pkg::ORDER_W-1:0] diff_m;
    logic                        tap_e;
    logic                        tap_m;
    logic                        bit_in;
    logic                        bit_out;
    fed_s   = '0;
    data_o  = '0;
    fed_o   = '0;
    diff_e  = '0;
    diff_m  = '0;
    tap_e   = 1'b0;
    tap_m   = 1'b0;
    bit_in  = 1'b0;
    bit_out = 1'b0;
    for (int j = 0; j < sss_pkg::BYTE_W; j++) begin
      bit_in = data_i[sss_pkg::BYTE_W-1-j];
      diff_e = sss_pkg::ORDER_W'(end_tap) - sss_pkg::ORDER_W'(j);
      diff_m = sss_pkg::ORDER_W'(mid_tap) - sss_pkg::ORDER_W'(j);
      if (!diff_e[sss_pkg::ORDER_W-1]) begin
        tap_e = eff_i[diff_e[sss_pkg::TAP_W-1:0]];
      end else begin
        tap_e = fed_s[~diff_e[sss_pkg::STEP_W-1:0]];
      end
      if (!diff_m[sss_pkg::ORDER_W-1]) begin
        tap_m = eff_i[diff_m[sss_pkg::TAP_W-1:0]];
      end else begin
        tap_m = fed_s[~diff_m[sss_pkg::STEP_W-1:0]];
      end
      bit_out = bit_in ^ tap_e ^ tap_m;
      fed_s[j] = (mode_i == sss_pkg::MODE_DESCRAMBLE) ? bit_in : bit_out;
      data_o[sss_pkg::BYTE_W-1-j] = bit_out;
      fed_o[sss_pkg::BYTE_W-1-j]  = fed_s[j];
    end
  end

endmodule

`default_nettype wire
